>>> sv/rdp_pkg.sv
`timescale 1ns / 1ps
package rdp_pkg;

    localparam int ROUTE_ENTRIES_DEF = 16;
    localparam int SEEN_ENTRIES_DEF  = 32;
    localparam int ADDR_W            = 32;
    localparam int HOP_W             = 8;
    localparam logic [HOP_W-1:0] HOP_MAX = '1;
    localparam logic [HOP_W-1:0] HOP_ONE = HOP_W'(1);

    // input kinds (s_tuser)
    localparam logic [1:0] FUNC_REQ    = 2'd0;
    localparam logic [1:0] FUNC_RESP   = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    typedef enum logic [2:0] {
        ACT_OWN_DROP    = 3'd0,
        ACT_DUP_DROP    = 3'd1,
        ACT_REBROADCAST = 3'd2,
        ACT_REPLY       = 3'd3,
        ACT_FORWARD     = 3'd4,
        ACT_ARRIVED     = 3'd5,
        ACT_HIT         = 3'd6,
        ACT_MISS        = 3'd7
    } action_t;

    // which route a table scan/update works on
    typedef enum logic [1:0] {
        SEL_SRC  = 2'd0,   // request: route to source via previous hop
        SEL_PREV = 2'd1,   // request: previous hop itself, metric 1
        SEL_DST  = 2'd2    // response / lookup: destination
    } key_sel_t;

    typedef struct packed {
        logic     seen_start;
        logic     seen_record;
        logic     route_start;
        logic     route_update;
        logic     out_load;
        key_sel_t key_sel;
        action_t  act;
    } rdp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       src_own;
        logic       dst_own;
        logic       seen_done;
        logic       seen_hit;
        logic       route_done;
        logic       route_found;
        logic       out_pending;
    } rdp_stat_t;

endpackage

>>> sv/rdp_ctrl.sv
`timescale 1ns / 1ps
module rdp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  rdp_pkg::rdp_stat_t stat,
    output rdp_pkg::rdp_cmd_t  cmd
);
    import rdp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEEN,
        ST_ROUTE,
        ST_UPD,
        ST_OUT
    } state_t;

    state_t   state_reg;
    rdp_cmd_t cmd_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign cmd      = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            cmd_reg.seen_start   <= 1'b0;
            cmd_reg.seen_record  <= 1'b0;
            cmd_reg.route_start  <= 1'b0;
            cmd_reg.route_update <= 1'b0;
            cmd_reg.out_load     <= 1'b0;
            cmd_reg.key_sel      <= SEL_DST;
            cmd_reg.act          <= ACT_MISS;
        end
        else
        begin
            cmd_reg.seen_start   <= 1'b0;
            cmd_reg.seen_record  <= 1'b0;
            cmd_reg.route_start  <= 1'b0;
            cmd_reg.route_update <= 1'b0;
            cmd_reg.out_load     <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE:
                begin
                    priority if (stat.func == FUNC_REQ)
                    begin
                        if (stat.src_own)
                        begin
                            cmd_reg.act <= ACT_OWN_DROP;
                            state_reg   <= ST_OUT;
                        end
                        else
                        begin
                            cmd_reg.seen_start <= 1'b1;
                            state_reg          <= ST_SEEN;
                        end
                    end
                    else if (stat.func == FUNC_RESP || stat.func == FUNC_LOOKUP)
                    begin
                        cmd_reg.key_sel     <= SEL_DST;
                        cmd_reg.route_start <= 1'b1;
                        state_reg           <= ST_ROUTE;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;   // unused kind: no result
                    end
                end
                ST_SEEN:
                begin
                    if (stat.seen_done)
                    begin
                        if (stat.seen_hit)
                        begin
                            cmd_reg.act <= ACT_DUP_DROP;
                            state_reg   <= ST_OUT;
                        end
                        else
                        begin
                            cmd_reg.seen_record <= 1'b1;
                            cmd_reg.key_sel     <= SEL_SRC;
                            cmd_reg.route_start <= 1'b1;
                            state_reg           <= ST_ROUTE;
                        end
                    end
                end
                ST_ROUTE:
                begin
                    if (stat.route_done)
                    begin
                        if (stat.func == FUNC_LOOKUP)
                        begin
                            cmd_reg.act <= stat.route_found ? ACT_HIT : ACT_MISS;
                            state_reg   <= ST_OUT;
                        end
                        else
                        begin
                            cmd_reg.route_update <= 1'b1;
                            state_reg            <= ST_UPD;
                        end
                    end
                end
                ST_UPD:
                begin
                    // update is written this cycle; a new scan starts after it
                    priority if (stat.func == FUNC_REQ && cmd_reg.key_sel == SEL_SRC)
                    begin
                        cmd_reg.key_sel     <= SEL_PREV;
                        cmd_reg.route_start <= 1'b1;
                        state_reg           <= ST_ROUTE;
                    end
                    else if (stat.func == FUNC_REQ)
                    begin
                        cmd_reg.act <= stat.dst_own ? ACT_REPLY : ACT_REBROADCAST;
                        state_reg   <= ST_OUT;
                    end
                    else
                    begin
                        cmd_reg.act <= stat.src_own ? ACT_ARRIVED : ACT_FORWARD;
                        state_reg   <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!stat.out_pending)
                    begin
                        cmd_reg.out_load <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/rdp_datapath.sv
`timescale 1ns / 1ps
module rdp_datapath
#(
    parameter int ROUTE_ENTRIES = rdp_pkg::ROUTE_ENTRIES_DEF,
    parameter int SEEN_ENTRIES  = rdp_pkg::SEEN_ENTRIES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       capture,
    input  logic [1:0]                 func,
    input  logic [rdp_pkg::ADDR_W-1:0] src_addr,
    input  logic [rdp_pkg::ADDR_W-1:0] dst_addr,
    input  logic [rdp_pkg::HOP_W-1:0]  hop_count,
    input  logic [rdp_pkg::ADDR_W-1:0] req_id,
    input  logic [rdp_pkg::ADDR_W-1:0] last_route_addr,
    input  logic [rdp_pkg::ADDR_W-1:0] toward_dst_addr,
    input  logic [rdp_pkg::ADDR_W-1:0] onward_addr,
    input  logic                       cfg_write,
    input  logic [rdp_pkg::ADDR_W-1:0] cfg_data,
    input  rdp_pkg::rdp_cmd_t          cmd,
    output rdp_pkg::rdp_stat_t         stat,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic [2:0]                 m_action,
    output logic [rdp_pkg::ADDR_W-1:0] m_target_addr,
    output logic [rdp_pkg::HOP_W-1:0]  m_out_hop,
    output logic [rdp_pkg::HOP_W-1:0]  m_route_metric,
    output logic                       m_table_full
);
    import rdp_pkg::*;

    localparam int RW = $clog2(ROUTE_ENTRIES);
    localparam int SW = $clog2(SEEN_ENTRIES);
    localparam int FW = $clog2(SEEN_ENTRIES + 1);
    localparam logic [RW-1:0] R_LAST = RW'(ROUTE_ENTRIES - 1);
    localparam logic [SW-1:0] S_LAST = SW'(SEEN_ENTRIES - 1);
    localparam logic [FW-1:0] S_FULL = FW'(SEEN_ENTRIES);

    // captured item and config
    logic [1:0]        func_reg;
    logic [ADDR_W-1:0] src_reg, dst_reg, rid_reg, last_reg, toward_reg, onward_reg;
    logic [HOP_W-1:0]  hop_reg;
    logic [ADDR_W-1:0] own_reg;

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            func_reg   <= func;
            src_reg    <= src_addr;
            dst_reg    <= dst_addr;
            hop_reg    <= hop_count;
            rid_reg    <= req_id;
            last_reg   <= last_route_addr;
            toward_reg <= toward_dst_addr;
            onward_reg <= onward_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg <= '0;
        end
        else if (cfg_write)
        begin
            own_reg <= cfg_data;
        end
    end

    // route key
    logic [ADDR_W-1:0] key_dest, key_next;
    logic [HOP_W-1:0]  key_cost;

    always_comb
    begin
        unique case (cmd.key_sel)
            SEL_SRC:
            begin
                key_dest = src_reg;
                key_next = last_reg;
                key_cost = hop_reg;
            end
            SEL_PREV:
            begin
                key_dest = last_reg;
                key_next = last_reg;
                key_cost = HOP_ONE;
            end
            default:
            begin
                key_dest = dst_reg;
                key_next = toward_reg;
                key_cost = hop_reg;
            end
        endcase
    end

    // ---------------- route table ----------------
    logic [ADDR_W-1:0] rt_dest_mem [ROUTE_ENTRIES];
    logic [ADDR_W-1:0] rt_next_mem [ROUTE_ENTRIES];
    logic [HOP_W-1:0]  rt_cost_mem [ROUTE_ENTRIES];
    logic [ROUTE_ENTRIES-1:0] rt_valid_reg;

    logic              r_busy_reg, r_chk_reg, r_done_reg;
    logic [RW-1:0]     r_issue_reg, r_chk_idx_reg;
    logic [ADDR_W-1:0] r_rd_dest_reg, r_rd_next_reg;
    logic [HOP_W-1:0]  r_rd_cost_reg;
    logic              r_rd_v_reg;
    logic              r_found_reg, r_free_found_reg;
    logic [RW-1:0]     r_hit_idx_reg, r_free_idx_reg;
    logic [ADDR_W-1:0] r_hit_next_reg;
    logic [HOP_W-1:0]  r_hit_cost_reg;
    logic              full_reg;

    // memory: one read, one write per cycle
    always_ff @(posedge clk)
    begin
        r_rd_dest_reg <= rt_dest_mem[r_issue_reg];
        r_rd_next_reg <= rt_next_mem[r_issue_reg];
        r_rd_cost_reg <= rt_cost_mem[r_issue_reg];
        if (cmd.route_update)
        begin
            if (r_found_reg)
            begin
                if (key_cost < r_hit_cost_reg)
                begin
                    rt_next_mem[r_hit_idx_reg] <= key_next;
                    rt_cost_mem[r_hit_idx_reg] <= key_cost;
                end
            end
            else if (r_free_found_reg)
            begin
                rt_dest_mem[r_free_idx_reg] <= key_dest;
                rt_next_mem[r_free_idx_reg] <= key_next;
                rt_cost_mem[r_free_idx_reg] <= key_cost;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_valid_reg     <= '0;
            r_busy_reg       <= 1'b0;
            r_chk_reg        <= 1'b0;
            r_done_reg       <= 1'b0;
            r_issue_reg      <= '0;
            r_chk_idx_reg    <= '0;
            r_rd_v_reg       <= 1'b0;
            r_found_reg      <= 1'b0;
            r_free_found_reg <= 1'b0;
            r_hit_idx_reg    <= '0;
            r_free_idx_reg   <= '0;
            r_hit_next_reg   <= '0;
            r_hit_cost_reg   <= '0;
            full_reg         <= 1'b0;
        end
        else
        begin
            r_done_reg <= 1'b0;
            if (capture)
            begin
                full_reg <= 1'b0;
            end
            if (cmd.route_start)
            begin
                r_busy_reg       <= 1'b1;
                r_chk_reg        <= 1'b0;
                r_issue_reg      <= '0;
                r_found_reg      <= 1'b0;
                r_free_found_reg <= 1'b0;
            end
            else
            begin
                r_chk_reg     <= r_busy_reg;
                r_chk_idx_reg <= r_issue_reg;
                r_rd_v_reg    <= rt_valid_reg[r_issue_reg];
                if (r_busy_reg)
                begin
                    r_issue_reg <= r_issue_reg + RW'(1);
                    if (r_issue_reg == R_LAST)
                    begin
                        r_busy_reg <= 1'b0;
                    end
                end
                if (r_chk_reg)
                begin
                    if (r_rd_v_reg && r_rd_dest_reg == key_dest && !r_found_reg)
                    begin
                        r_found_reg    <= 1'b1;
                        r_hit_idx_reg  <= r_chk_idx_reg;
                        r_hit_next_reg <= r_rd_next_reg;
                        r_hit_cost_reg <= r_rd_cost_reg;
                    end
                    if (!r_rd_v_reg && !r_free_found_reg)
                    begin
                        r_free_found_reg <= 1'b1;
                        r_free_idx_reg   <= r_chk_idx_reg;
                    end
                    if (r_chk_idx_reg == R_LAST)
                    begin
                        r_done_reg <= 1'b1;
                    end
                end
            end
            if (cmd.route_update && !r_found_reg)
            begin
                if (r_free_found_reg)
                begin
                    rt_valid_reg[r_free_idx_reg] <= 1'b1;
                end
                else
                begin
                    full_reg <= 1'b1;
                end
            end
        end
    end

    // ---------------- seen store ----------------
    logic [ADDR_W-1:0] sn_src_mem [SEEN_ENTRIES];
    logic [ADDR_W-1:0] sn_id_mem  [SEEN_ENTRIES];

    logic              s_busy_reg, s_chk_reg, s_done_reg, s_hit_reg;
    logic [SW-1:0]     s_issue_reg, s_chk_idx_reg, s_wp_reg;
    logic [FW-1:0]     s_fill_reg;
    logic [ADDR_W-1:0] s_rd_src_reg, s_rd_id_reg;
    logic              s_rd_v_reg;

    always_ff @(posedge clk)
    begin
        s_rd_src_reg <= sn_src_mem[s_issue_reg];
        s_rd_id_reg  <= sn_id_mem[s_issue_reg];
        if (cmd.seen_record)
        begin
            sn_src_mem[s_wp_reg] <= src_reg;
            sn_id_mem[s_wp_reg]  <= rid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_busy_reg    <= 1'b0;
            s_chk_reg     <= 1'b0;
            s_done_reg    <= 1'b0;
            s_hit_reg     <= 1'b0;
            s_issue_reg   <= '0;
            s_chk_idx_reg <= '0;
            s_wp_reg      <= '0;
            s_fill_reg    <= '0;
            s_rd_v_reg    <= 1'b0;
        end
        else
        begin
            s_done_reg <= 1'b0;
            if (cmd.seen_start)
            begin
                s_busy_reg  <= 1'b1;
                s_chk_reg   <= 1'b0;
                s_issue_reg <= '0;
                s_hit_reg   <= 1'b0;
            end
            else
            begin
                s_chk_reg     <= s_busy_reg;
                s_chk_idx_reg <= s_issue_reg;
                // entries below the fill count hold data
                s_rd_v_reg    <= (FW'(s_issue_reg) < s_fill_reg);
                if (s_busy_reg)
                begin
                    s_issue_reg <= s_issue_reg + SW'(1);
                    if (s_issue_reg == S_LAST)
                    begin
                        s_busy_reg <= 1'b0;
                    end
                end
                if (s_chk_reg)
                begin
                    if (s_rd_v_reg && s_rd_src_reg == src_reg && s_rd_id_reg == rid_reg)
                    begin
                        s_hit_reg <= 1'b1;
                    end
                    if (s_chk_idx_reg == S_LAST)
                    begin
                        s_done_reg <= 1'b1;
                    end
                end
            end
            if (cmd.seen_record)
            begin
                s_wp_reg <= (s_wp_reg == S_LAST) ? '0 : s_wp_reg + SW'(1);
                if (s_fill_reg != S_FULL)
                begin
                    s_fill_reg <= s_fill_reg + FW'(1);
                end
            end
        end
    end

    // ---------------- output register ----------------
    logic [HOP_W-1:0] hop_inc;
    logic             m_tvalid_reg;
    action_t          out_act_reg;

    assign hop_inc = (hop_reg == HOP_MAX) ? HOP_MAX : hop_reg + HOP_ONE;

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_act_reg    <= cmd.act;
            m_target_addr  <= '0;
            m_out_hop      <= '0;
            m_route_metric <= '0;
            m_table_full   <= full_reg;
            unique case (cmd.act)
                ACT_REBROADCAST:
                begin
                    m_out_hop <= hop_inc;
                end
                ACT_REPLY:
                begin
                    m_target_addr <= last_reg;
                    m_out_hop     <= HOP_ONE;
                end
                ACT_FORWARD:
                begin
                    m_target_addr <= onward_reg;
                    m_out_hop     <= hop_inc;
                end
                ACT_HIT:
                begin
                    m_target_addr  <= r_hit_next_reg;
                    m_route_metric <= r_hit_cost_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_action = out_act_reg;

    assign stat.func        = func_reg;
    assign stat.src_own     = (src_reg == own_reg);
    assign stat.dst_own     = (dst_reg == own_reg);
    assign stat.seen_done   = s_done_reg;
    assign stat.seen_hit    = s_hit_reg;
    assign stat.route_done  = r_done_reg;
    assign stat.route_found = r_found_reg;
    assign stat.out_pending = m_tvalid_reg && !m_tready;

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(m_tvalid_reg && !m_tready))
        else $error("result loaded over a pending result");

    // the two scans never run together
    a_one_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !(r_busy_reg && s_busy_reg))
        else $error("route and seen scans overlap");

    // fill count bounded by store depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s_fill_reg <= S_FULL)
        else $error("seen fill count overflow");

    // table update only after a finished scan
    a_upd_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.route_update |-> !r_busy_reg && !r_chk_reg)
        else $error("route update during scan");

endmodule

>>> sv/route_discovery_packet_handler_unit.sv
`timescale 1ns / 1ps
// Route discovery handler for one node. Each input word is a route request,
// a route response or a table lookup (s_tuser); each yields one result word
// with the action taken (m_tuser). The route table and the seen store are
// memories with one read and one write port, searched one entry per cycle,
// so latency is set by those scans. A lookup runs one route scan; a response
// runs one route scan and a table update; a new request runs a seen scan,
// then two route scans, each with its table update; a duplicate request runs
// only the seen scan and an own request none. An unused kind yields nothing
// and frees the input. One word is processed at a time; the next is accepted
// at the edge where the previous result enters the output register, so a
// word holds the input through all its scans, and longer while a previous
// result still waits on m_tready. Configuration (own address) is to be
// written by the user only while idle; the block does not enforce this, and
// cfg_ready stays high. No clearing pass is needed after reset.
module route_discovery_packet_handler_unit
#(
    parameter int ROUTE_ENTRIES = rdp_pkg::ROUTE_ENTRIES_DEF,
    parameter int SEEN_ENTRIES  = rdp_pkg::SEEN_ENTRIES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // src_addr[31:0], dst_addr[63:32], hop_count[71:64], req_id[103:72],
    // last_route_addr[135:104], toward_dst_addr[167:136], onward_addr[199:168]
    input  logic [199:0] s_tdata,
    // func[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // target_addr[31:0], out_hop[39:32], route_metric[47:40], table_full[48],
    // zero[55:49]
    output logic [55:0]  m_tdata,
    // action[2:0]
    output logic [2:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);
    import rdp_pkg::*;

    rdp_cmd_t          cmd;
    rdp_stat_t         stat;
    logic              capture;
    logic [ADDR_W-1:0] target_addr;
    logic [HOP_W-1:0]  out_hop, route_metric;
    logic              table_full;

    assign capture   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    rdp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rdp_datapath
    #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES),
        .SEEN_ENTRIES  (SEEN_ENTRIES)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .capture         (capture),
        .func            (s_tuser),
        .src_addr        (s_tdata[31:0]),
        .dst_addr        (s_tdata[63:32]),
        .hop_count       (s_tdata[71:64]),
        .req_id          (s_tdata[103:72]),
        .last_route_addr (s_tdata[135:104]),
        .toward_dst_addr (s_tdata[167:136]),
        .onward_addr     (s_tdata[199:168]),
        .cfg_write       (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .stat            (stat),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .m_action        (m_tuser),
        .m_target_addr   (target_addr),
        .m_out_hop       (out_hop),
        .m_route_metric  (route_metric),
        .m_table_full    (table_full)
    );

    assign m_tdata = {7'b0, table_full, route_metric, out_hop, target_addr};

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import rdp_pkg::*;

    localparam int ROUTES    = ROUTE_ENTRIES_DEF;
    localparam int SEEN      = SEEN_ENTRIES_DEF;
    localparam int MAX_CYCLES = 1500000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  hop;
        logic [31:0] rid;
        logic [31:0] last;
        logic [31:0] toward;
        logic [31:0] onward;
    } packet_t;

    typedef struct {
        action_t     act;
        logic [31:0] send;
        logic [7:0]  hop;
        logic [7:0]  metric;
        logic        full;
    } outcome_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [55:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [31:0]  cfg_data;

    route_discovery_packet_handler_unit dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor state
    logic [31:0] node_addr;
    logic        rt_valid [ROUTES];
    logic [31:0] rt_dest  [ROUTES];
    logic [31:0] rt_next  [ROUTES];
    logic [7:0]  rt_cost  [ROUTES];
    logic        sn_valid [SEEN];
    logic [31:0] sn_src   [SEEN];
    logic [31:0] sn_id    [SEEN];
    int          sn_ptr;

    outcome_t    pending_outcomes[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          errors;
    longint      cycle_count;
    logic [31:0] addr_pool[8];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int route_index(logic [31:0] dest);
        for (int i = 0; i < ROUTES; i++)
            if (rt_valid[i] && rt_dest[i] == dest)
                return i;
        return -1;
    endfunction

    // returns 1 when a new route found no free entry
    function automatic logic learn(logic [31:0] dest, logic [31:0] nxt, logic [7:0] cost);
        int i;
        i = route_index(dest);
        if (i >= 0)
        begin
            if (cost < rt_cost[i])
            begin
                rt_next[i] = nxt;
                rt_cost[i] = cost;
            end
            return 1'b0;
        end
        for (i = 0; i < ROUTES; i++)
            if (!rt_valid[i])
            begin
                rt_valid[i] = 1'b1;
                rt_dest[i] = dest;
                rt_next[i] = nxt;
                rt_cost[i] = cost;
                return 1'b0;
            end
        return 1'b1;
    endfunction

    function automatic logic [7:0] bump_hop(logic [7:0] h);
        return (h == HOP_MAX) ? HOP_MAX : h + 8'd1;
    endfunction

    // handle one packet; returns 0 for the unused kind
    function automatic logic handle_packet(packet_t p, output outcome_t o);
        logic dup;
        logic f1;
        logic f2;
        int   i;
        o = '{ACT_OWN_DROP, 32'd0, 8'd0, 8'd0, 1'b0};
        case (p.func)
            FUNC_REQ:
            begin
                dup = 1'b0;
                for (i = 0; i < SEEN; i++)
                    if (sn_valid[i] && sn_src[i] == p.src && sn_id[i] == p.rid)
                        dup = 1'b1;
                if (p.src == node_addr)
                    o.act = ACT_OWN_DROP;
                else if (dup)
                    o.act = ACT_DUP_DROP;
                else
                begin
                    sn_valid[sn_ptr] = 1'b1;
                    sn_src[sn_ptr] = p.src;
                    sn_id[sn_ptr] = p.rid;
                    sn_ptr = (sn_ptr + 1) % SEEN;
                    f1 = learn(p.src, p.last, p.hop);
                    f2 = learn(p.last, p.last, HOP_ONE);
                    o.full = f1 | f2;
                    if (p.dst != node_addr)
                    begin
                        o.act = ACT_REBROADCAST;
                        o.hop = bump_hop(p.hop);
                    end
                    else
                    begin
                        o.act = ACT_REPLY;
                        o.send = p.last;
                        o.hop = HOP_ONE;
                    end
                end
            end
            FUNC_RESP:
            begin
                o.full = learn(p.dst, p.toward, p.hop);
                if (p.src != node_addr)
                begin
                    o.act = ACT_FORWARD;
                    o.send = p.onward;
                    o.hop = bump_hop(p.hop);
                end
                else
                    o.act = ACT_ARRIVED;
            end
            FUNC_LOOKUP:
            begin
                i = route_index(p.dst);
                if (i >= 0)
                begin
                    o.act = ACT_HIT;
                    o.send = rt_next[i];
                    o.metric = rt_cost[i];
                end
                else
                    o.act = ACT_MISS;
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // send one word, after a random gap; tvalid stays up between back-to-back words
    task automatic send_packet(packet_t p);
        outcome_t o;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        if (handle_packet(p, o))
            pending_outcomes.insert(pending_outcomes.size(), o);
        s_tvalid <= 1'b1;
        s_tuser <= p.func;
        s_tdata <= {p.onward, p.toward, p.last, p.rid, p.hop, p.dst, p.src};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        // unused-kind words may still be in flight
        repeat (120) @(posedge clk);
    endtask

    task automatic write_own_address(logic [31:0] a);
        cfg_valid <= 1'b1;
        cfg_data <= a;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        node_addr = a;
    endtask

    function automatic logic [31:0] pick_addr();
        if ($urandom_range(9) < 8)
            return addr_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    function automatic packet_t random_packet();
        packet_t p;
        p.func = ($urandom_range(19) == 0) ? FUNC_UNUSED : 2'($urandom_range(2));
        p.src = ($urandom_range(9) == 0) ? node_addr : pick_addr();
        p.dst = ($urandom_range(5) == 0) ? node_addr : pick_addr();
        p.hop = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6));
        p.rid = ($urandom_range(2) == 0) ? 32'($urandom_range(3)) : $urandom;
        p.last = pick_addr();
        p.toward = pick_addr();
        p.onward = $urandom;
        return p;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                e = pending_outcomes.pop_front();
                if (m_tuser != e.act)
                begin
                    $error("action exp %0d got %0d", e.act, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] != e.send)
                begin
                    $error("target_addr exp %h got %h", e.send, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[39:32] != e.hop)
                begin
                    $error("out_hop exp %0d got %0d", e.hop, m_tdata[39:32]);
                    errors++;
                end
                if (m_tdata[47:40] != e.metric)
                begin
                    $error("route_metric exp %0d got %0d", e.metric, m_tdata[47:40]);
                    errors++;
                end
                if (m_tdata[48] != e.full)
                begin
                    $error("table_full exp %0d got %0d", e.full, m_tdata[48]);
                    errors++;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // extremes, own drop, duplicate, reply, arrival, hop saturation, unused kind
    task automatic test_directed;
        packet_t p;
        write_own_address(32'hFFFF_FFFF);
        p = '{FUNC_LOOKUP, 32'd0, 32'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        send_packet(p);
        p = '{FUNC_REQ, 32'hFFFF_FFFF, 32'd5, 8'd3, 32'd1, 32'd7, 32'd0, 32'd0};
        send_packet(p);
        p = '{FUNC_REQ, 32'd0, 32'hFFFF_FFFE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
              32'd0, 32'd0};
        send_packet(p);
        send_packet(p);
        p = '{FUNC_REQ, 32'd9, 32'hFFFF_FFFF, 8'd0, 32'd0, 32'd3, 32'd0, 32'd0};
        send_packet(p);
        p = '{FUNC_RESP, 32'd1, 32'd40, 8'hFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        send_packet(p);
        p = '{FUNC_RESP, 32'hFFFF_FFFF, 32'd40, 8'd0, 32'd0, 32'd0, 32'd8, 32'd2};
        send_packet(p);
        p = '{FUNC_LOOKUP, 32'd0, 32'd40, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        send_packet(p);
        p = '{FUNC_LOOKUP, 32'd0, 32'd0, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        send_packet(p);
        p = '{FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        send_packet(p);
        drain();
    endtask

    // fill the table past capacity with fresh destinations
    task automatic test_table_full;
        packet_t p;
        write_own_address(32'd0);
        for (int i = 0; i < 20; i++)
        begin
            p = '{FUNC_RESP, 32'd77, 32'h1000 + i, 8'd4, 32'd0, 32'd0, 32'h55, 32'h66};
            send_packet(p);
        end
        p = '{FUNC_LOOKUP, 32'd0, 32'h1000 + 19, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        send_packet(p);
        drain();
    endtask

    // random traffic; the table and seen store carry over between passes, and the address pool is refilled per pass
    task automatic test_random(int count, logic [31:0] own);
        write_own_address(own);
        for (int i = 0; i < 8; i++)
            addr_pool[i] = (i < 4) ? 32'($urandom_range(20)) : $urandom;
        addr_pool[0] = own;
        for (int i = 0; i < count; i++)
        begin
            send_packet(random_packet());
            // hold off until the block has caught up
            if (i == count / 2)
            begin
                s_tvalid <= 1'b0;
                while (pending_outcomes.size() != 0)
                    @(posedge clk);
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_REQ;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        cycle_count = 0;
        node_addr = 32'd0;
        sn_ptr = 0;
        for (int i = 0; i < ROUTES; i++)
            rt_valid[i] = 1'b0;
        for (int i = 0; i < SEEN; i++)
            sn_valid[i] = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 76;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_random(450, $urandom);
        send_idle_pct = 76;
        recv_idle_pct = 10;
        test_random(450, 32'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(450, 32'hFFFF_FFFF);
        if (errors == 0 && pending_outcomes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> route_discovery_packet_handler_unit.f
sv/rdp_pkg.sv
sv/rdp_ctrl.sv
sv/rdp_datapath.sv
sv/route_discovery_packet_handler_unit.sv
sim/tb.sv
